// ===== design/srec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3 record loader package
// Character codes, column positions, result types and the hex digit decoder
// shared by the loader files.
// ----------------------------------------------------------------------------
package srec_pkg;

   localparam int unsigned ColWidth = 10;

   // Image size in bytes; results at or past it are flagged as outside.
   localparam logic [31:0] IMAGE_BYTES = 32'd262144;

   // Character codes
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_S       = 8'h53;
   localparam logic [7:0] CH_3       = 8'h33;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_LC_A    = 8'h61;
   localparam logic [7:0] CH_LC_F    = 8'h66;
   localparam logic [7:0] CH_UC_A    = 8'h41;
   localparam logic [7:0] CH_UC_F    = 8'h46;

   // Column positions within a line
   localparam logic [ColWidth-1:0] COL_TYPE_S    = 10'd0;
   localparam logic [ColWidth-1:0] COL_TYPE_3    = 10'd1;
   localparam logic [ColWidth-1:0] COL_COUNT_HI  = 10'd2;
   localparam logic [ColWidth-1:0] COL_COUNT_LO  = 10'd3;
   localparam logic [ColWidth-1:0] ADDR_LAST_COL = 10'd11;
   localparam logic [ColWidth-1:0] COL_MAX       = 10'd1023;

   // Count field bytes that are not data: four address bytes and checksum
   localparam logic [7:0] COUNT_OVERHEAD = 8'd5;

   typedef struct packed {
      logic       bad;
      logic [3:0] nib;
   } hex_type;

   typedef struct packed {
      logic [31:0] offset;
      logic [7:0]  data_byte;
      logic        in_image;
      logic        hex_error;
      logic        last_in_record;
   } srec_rsp_type;

   typedef struct packed {
      logic         valid;
      srec_rsp_type beat;
   } srec_emit_type;

   // Decode one hex digit; anything else reads as zero and flags bad.
   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type h;
      h.bad = 1'b0;
      h.nib = 4'd0;
      if (c >= CH_0 && c <= CH_9) begin
         h.nib = 4'(c - CH_0);
      end else if (c >= CH_LC_A && c <= CH_LC_F) begin
         h.nib = 4'(c - CH_LC_A + 8'd10);
      end else if (c >= CH_UC_A && c <= CH_UC_F) begin
         h.nib = 4'(c - CH_UC_A + 8'd10);
      end else begin
         h.bad = 1'b1;
      end
      return h;
   endfunction

endpackage

// ===== design/srec_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one record text character per beat.
// ----------------------------------------------------------------------------
interface srec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

// ===== design/srec_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data byte channel
// Valid/ready channel carrying one decoded data byte and its flags per beat.
// ----------------------------------------------------------------------------
interface srec_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] offset;
   logic [7:0]  data_byte;
   logic        in_image;
   logic        hex_error;
   logic        last_in_record;

   modport source (output valid, output offset, output data_byte, output in_image,
                   output hex_error, output last_in_record, input ready);
   modport sink   (input valid, input offset, input data_byte, input in_image,
                   input hex_error, input last_in_record, output ready);
endinterface

// ===== design/srec_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3 line parser
// Tracks the column of each line, decodes count and address, and produces
// one data byte result on every second data digit.
// ----------------------------------------------------------------------------
module srec_parse import srec_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    ch,
   output srec_emit_type emit
);

   logic [ColWidth-1:0] col_ff, col_in;
   logic                skip_ff, skip_in;
   logic [7:0]          data_count_ff, data_count_in;
   logic [31:0]         rec_addr_ff, rec_addr_in;
   logic [31:0]         base_ff, base_in;
   logic                base_valid_ff, base_valid_in;
   logic [3:0]          high_ff, high_in;
   logic                nib_err_ff, nib_err_in;
   logic [7:0]          sent_ff, sent_in;
   logic [31:0]         offset_ff, offset_in;

   hex_type             hex;
   logic [7:0]          count_byte;
   logic [31:0]         addr_next;

   assign hex        = hex_value(ch);
   assign count_byte = {high_ff, hex.nib};
   assign addr_next  = {rec_addr_ff[27:0], hex.nib};

   always_comb begin
      col_in        = col_ff;
      skip_in       = skip_ff;
      data_count_in = data_count_ff;
      rec_addr_in   = rec_addr_ff;
      base_in       = base_ff;
      base_valid_in = base_valid_ff;
      high_in       = high_ff;
      nib_err_in    = nib_err_ff;
      sent_in       = sent_ff;
      offset_in     = offset_ff;
      emit          = '0;

      if (step) begin
         if (ch == CH_NEWLINE) begin
            col_in  = '0;
            skip_in = 1'b0;
         end else begin
            if (col_ff != COL_MAX) begin
               col_in = col_ff + 1'b1;
            end
            if (!skip_ff) begin
               if (col_ff == COL_TYPE_S) begin
                  skip_in = (ch != CH_S);
               end else if (col_ff == COL_TYPE_3) begin
                  skip_in = (ch != CH_3);
               end else if (col_ff == COL_COUNT_HI) begin
                  high_in = hex.nib;
               end else if (col_ff == COL_COUNT_LO) begin
                  data_count_in = (count_byte >= COUNT_OVERHEAD) ?
                                  count_byte - COUNT_OVERHEAD : 8'd0;
               end else if (col_ff <= ADDR_LAST_COL) begin
                  rec_addr_in = addr_next;
                  if (col_ff == ADDR_LAST_COL) begin
                     // Address complete: latch the base once, start the offset
                     sent_in   = '0;
                     offset_in = addr_next - (base_valid_ff ? base_ff : addr_next);
                     if (!base_valid_ff) begin
                        base_in       = addr_next;
                        base_valid_in = 1'b1;
                     end
                  end
               end else if (sent_ff < data_count_ff) begin
                  if (!col_ff[0]) begin
                     high_in    = hex.nib;
                     nib_err_in = hex.bad;
                  end else begin
                     emit.valid               = 1'b1;
                     emit.beat.offset         = offset_ff;
                     emit.beat.data_byte      = {high_ff, hex.nib};
                     emit.beat.in_image       = (offset_ff < IMAGE_BYTES);
                     emit.beat.hex_error      = nib_err_ff | hex.bad;
                     emit.beat.last_in_record =
                        ({1'b0, sent_ff} + 9'd1 == {1'b0, data_count_ff});
                     sent_in   = sent_ff + 8'd1;
                     offset_in = offset_ff + 32'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         skip_ff       <= 1'b0;
         data_count_ff <= '0;
         rec_addr_ff   <= '0;
         base_ff       <= '0;
         base_valid_ff <= 1'b0;
         high_ff       <= '0;
         nib_err_ff    <= 1'b0;
         sent_ff       <= '0;
         offset_ff     <= '0;
      end else begin
         col_ff        <= col_in;
         skip_ff       <= skip_in;
         data_count_ff <= data_count_in;
         rec_addr_ff   <= rec_addr_in;
         base_ff       <= base_in;
         base_valid_ff <= base_valid_in;
         high_ff       <= high_in;
         nib_err_ff    <= nib_err_in;
         sent_ff       <= sent_in;
         offset_ff     <= offset_in;
      end
   end

endmodule

// ===== design/srec_s3_record_loader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3 record loader
// Parses S-record text one character per beat and delivers the data bytes
// of every S3 record with their offset from the first record's address.
// ----------------------------------------------------------------------------
// The loader takes one character per clock and never stalls the input while
// the output register is empty or being drained in the same cycle. Each
// character is parsed in the cycle it is accepted; a data byte comes out of
// the result register in the cycle after its second hex digit, so a record with
// N data bytes yields N beats spread over its 2N data characters. Lines that
// do not start with "S3" are skipped to the next newline. The first complete
// S3 address becomes the base for all offsets; offsets wrap modulo 2^32 and
// in_image drops for offsets at or past the image size. A digit that is not
// hex decodes as zero and raises hex_error on its byte. The checksum and any
// characters after the last data byte are ignored. The only throttle is the
// single result register: input ready holds low only while a beat waits and
// the sink is not taking it.
// ----------------------------------------------------------------------------
module srec_s3_record_loader import srec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   srec_req_if.sink    req_bus,
   srec_rsp_if.source  rsp_bus
);

   srec_emit_type emit;
   logic          accept;

   logic          rsp_valid_ff, rsp_valid_in;
   srec_rsp_type  rsp_beat_ff, rsp_beat_in;

   // Accept a character whenever the result register is free or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   srec_parse u_parse (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .ch    (req_bus.ch),
      .emit  (emit)
   );

   // Load a new beat when the parser emits, drop the old one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = emit.beat;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.offset         = rsp_beat_ff.offset;
   assign rsp_bus.data_byte      = rsp_beat_ff.data_byte;
   assign rsp_bus.in_image       = rsp_beat_ff.in_image;
   assign rsp_bus.hex_error      = rsp_beat_ff.hex_error;
   assign rsp_bus.last_in_record = rsp_beat_ff.last_in_record;

   // The parser only produces a beat for an accepted character
   a_emit_needs_accept: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> accept)
      else $error("parser emitted without an accepted character");

   // An emitted beat is presented on the output in the next cycle
   a_emit_reaches_output: assert property (@(posedge clock) disable iff (reset)
      emit.valid |=> rsp_bus.valid)
      else $error("emitted beat did not reach the output register");

   // A waiting beat that is not taken is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !emit.valid)
      else $error("pending beat overwritten");

   // An empty output register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("input stalled with empty output register");

endmodule
